// ----- rtl/cca_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cluster chain allocator package
// Shared widths, codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package cca_pkg;

  // Table geometry and field widths
  localparam int unsigned MAX_CLUSTERS_DEF = 1024;
  localparam int unsigned LINK_W           = 11;
  localparam int unsigned KIND_W           = 3;
  localparam int unsigned ST_W             = 2;

  // Stored link values and register reset values
  localparam logic [LINK_W-1:0] LINK_FREE   = '0;
  localparam logic [LINK_W-1:0] END_MARK    = '1;
  localparam logic [LINK_W-1:0] COUNT_RESET = 11'd1024;
  localparam logic [LINK_W-1:0] PTR_RESET   = 11'd1;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NEXT       = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LINK       = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MARK_END   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FREE_CHAIN = 3'd4;
  localparam logic [KIND_W-1:0] KIND_FREE_ONE   = 3'd5;

  // Response status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_CORRUPT = 2'd1;
  localparam logic [ST_W-1:0] ST_NOSPC   = 2'd2;

  // Table write data select
  typedef enum logic [1:0] {
    WSEL_ZERO,
    WSEL_END,
    WSEL_LINK
  } wsel_e;

  // Result cluster select
  typedef enum logic [1:0] {
    RES_ZERO,
    RES_CUR,
    RES_RD
  } res_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic              load;        // capture request beat
    logic              clr_step;    // write zero at sweep address, advance
    logic              alloc_init;  // set scan start, clear count
    logic              wr;          // write table at current cluster
    wsel_e             wsel;
    logic              scan_adv;    // step scan pointer with wrap
    logic              alloc_take;  // move next-fit pointer past current
    logic              release_ptr; // lower next-fit pointer to current
    logic              chain_adv;   // move to successor, count step
    logic              fin;         // capture result
    logic [ST_W-1:0]   fin_st;
    res_sel_e          fin_res;
    logic              out_load;    // move result into output register
  } cca_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic              clear_last;
    logic [KIND_W-1:0] kind;
    logic              cur_zero;
    logic              cur_in_range;
    logic              n_zero;
    logic              rd_zero;
    logic              rd_end;
    logic              rd_in_range;
    logic              scan_last;
    logic              steps_over;
  } cca_sts_t;

endpackage
`default_nettype wire

// ----- rtl/cca_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cluster chain allocator channels
// Request and response valid/ready channels with their payloads.
// ----------------------------------------------------------------------------
interface cca_req_if
  import cca_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [LINK_W-1:0] cluster;
  logic [LINK_W-1:0] link_value;

  modport source (output valid, kind, cluster, link_value, input ready);
  modport sink   (input valid, kind, cluster, link_value, output ready);
endinterface

interface cca_rsp_if
  import cca_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [LINK_W-1:0] cluster_out;

  modport source (output valid, status, cluster_out, input ready);
  modport sink   (input valid, status, cluster_out, output ready);
endinterface
`default_nettype wire

// ----- rtl/cca_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cca_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write on enable, read every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/cca_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cluster chain allocator datapath
// Link table RAM, next-fit pointer, walk registers, result and output stage.
// ----------------------------------------------------------------------------
module cca_datapath
  import cca_pkg::*;
#(
  parameter int unsigned MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [LINK_W-1:0] cfg_wdata_i,
  input  wire logic [KIND_W-1:0] req_kind_i,
  input  wire logic [LINK_W-1:0] req_cluster_i,
  input  wire logic [LINK_W-1:0] req_link_value_i,
  input  wire cca_cmd_t          cmd_i,
  output cca_sts_t               sts_o,
  output logic      [ST_W-1:0]   rsp_status_o,
  output logic      [LINK_W-1:0] rsp_cluster_out_o
);

  localparam int unsigned DEPTH = MAX_CLUSTERS + 1;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [LINK_W-1:0] cfg_q, cfg_d;
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [LINK_W-1:0] cur_q, cur_d;
  logic [LINK_W-1:0] lv_q, lv_d;
  logic [LINK_W-1:0] cnt_q, cnt_d;
  logic [LINK_W-1:0] ptr_q, ptr_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [ST_W-1:0]   res_st_q, res_st_d;
  logic [LINK_W-1:0] res_cl_q, res_cl_d;
  logic [ST_W-1:0]   out_st_q, out_st_d;
  logic [LINK_W-1:0] out_cl_q, out_cl_d;

  logic [LINK_W-1:0] count;
  logic [LINK_W-1:0] scan_start;
  logic [LINK_W-1:0] succ;
  logic [LINK_W:0]   cnt_inc;
  logic              ptr_valid;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     cur_addr;
  logic [LINK_W-1:0] ram_wdata;
  logic [LINK_W-1:0] ram_rdata;

  // Clamp the configured count to the table size
  assign count = (32'(cfg_q) > MAX_CLUSTERS) ? LINK_W'(MAX_CLUSTERS) : cfg_q;

  assign cur_addr   = AW'(cur_q);
  assign ptr_valid  = (ptr_q != '0) && (ptr_q <= count);
  assign scan_start = ptr_valid ? ptr_q : PTR_RESET;
  assign succ       = (ram_rdata == END_MARK) ? LINK_FREE : ram_rdata;
  assign cnt_inc    = {1'b0, cnt_q} + (LINK_W + 1)'(1);

  // Status toward the controller
  always_comb begin
    sts_o.clear_last   = (clr_q == AW'(MAX_CLUSTERS));
    sts_o.kind         = kind_q;
    sts_o.cur_zero     = (cur_q == '0);
    sts_o.cur_in_range = (cur_q != '0) && (cur_q <= count);
    sts_o.n_zero       = (count == '0);
    sts_o.rd_zero      = (ram_rdata == LINK_FREE);
    sts_o.rd_end       = (ram_rdata == END_MARK);
    sts_o.rd_in_range  = (ram_rdata != '0) && (ram_rdata <= count);
    sts_o.scan_last    = (cnt_inc == {1'b0, count});
    sts_o.steps_over   = (cnt_inc > {1'b0, count});
  end

  // Table write port: reset sweep or current cluster
  always_comb begin
    ram_we    = cmd_i.clr_step | cmd_i.wr;
    ram_waddr = cmd_i.clr_step ? clr_q : cur_addr;
    case (cmd_i.wsel)
      WSEL_END:  ram_wdata = END_MARK;
      WSEL_LINK: ram_wdata = lv_q;
      default:   ram_wdata = LINK_FREE;
    endcase
    if (cmd_i.clr_step) begin
      ram_wdata = LINK_FREE;
    end
  end

  cca_ram #(
    .WIDTH (LINK_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cur_addr),
    .rdata_o (ram_rdata)
  );

  // Next-state for walk, pointer and result registers
  always_comb begin
    cfg_d    = cfg_we_i ? cfg_wdata_i : cfg_q;
    kind_d   = kind_q;
    cur_d    = cur_q;
    lv_d     = lv_q;
    cnt_d    = cnt_q;
    ptr_d    = ptr_q;
    clr_d    = clr_q;
    res_st_d = res_st_q;
    res_cl_d = res_cl_q;
    out_st_d = out_st_q;
    out_cl_d = out_cl_q;

    // Capture the request beat
    if (cmd_i.load) begin
      kind_d = req_kind_i;
      cur_d  = req_cluster_i;
      lv_d   = req_link_value_i;
      cnt_d  = '0;
    end

    // Advance the reset sweep
    if (cmd_i.clr_step) begin
      clr_d = clr_q + AW'(1);
    end

    // Allocation scan
    if (cmd_i.alloc_init) begin
      cur_d = scan_start;
      cnt_d = '0;
    end
    if (cmd_i.scan_adv) begin
      cur_d = (cur_q == count) ? PTR_RESET : cur_q + LINK_W'(1);
      cnt_d = cnt_inc[LINK_W-1:0];
    end
    if (cmd_i.alloc_take) begin
      ptr_d = cur_q + LINK_W'(1);
    end

    // Release lowers the next-fit pointer
    if (cmd_i.release_ptr && (cur_q < ptr_q)) begin
      ptr_d = cur_q;
    end

    // Chain walk
    if (cmd_i.chain_adv) begin
      cur_d = succ;
      cnt_d = cnt_inc[LINK_W-1:0];
    end

    // Result capture, cluster forced to zero on failure
    if (cmd_i.fin) begin
      res_st_d = cmd_i.fin_st;
      case (cmd_i.fin_res)
        RES_CUR: res_cl_d = cur_q;
        RES_RD:  res_cl_d = ram_rdata;
        default: res_cl_d = LINK_FREE;
      endcase
      if (cmd_i.fin_st != ST_OK) begin
        res_cl_d = LINK_FREE;
      end
    end

    // Output register
    if (cmd_i.out_load) begin
      out_st_d = res_st_q;
      out_cl_d = res_cl_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= COUNT_RESET;
      ptr_q <= PTR_RESET;
      clr_q <= '0;
    end else begin
      cfg_q <= cfg_d;
      ptr_q <= ptr_d;
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    cur_q    <= cur_d;
    lv_q     <= lv_d;
    cnt_q    <= cnt_d;
    res_st_q <= res_st_d;
    res_cl_q <= res_cl_d;
    out_st_q <= out_st_d;
    out_cl_q <= out_cl_d;
  end

  assign rsp_status_o      = out_st_q;
  assign rsp_cluster_out_o = out_cl_q;

endmodule
`default_nettype wire

// ----- rtl/cca_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cluster chain allocator controller
// Sequences the reset sweep, request decode, table scans and chain walks.
// ----------------------------------------------------------------------------
module cca_ctrl
  import cca_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     req_valid_i,
  output logic          req_ready_o,
  output logic          rsp_valid_o,
  input  wire logic     rsp_ready_i,
  input  wire cca_sts_t sts_i,
  output cca_cmd_t      cmd_o
);

  localparam logic [3:0] S_CLEAR      = 4'd0;
  localparam logic [3:0] S_IDLE       = 4'd1;
  localparam logic [3:0] S_DISPATCH   = 4'd2;
  localparam logic [3:0] S_SCAN_RD    = 4'd3;
  localparam logic [3:0] S_SCAN_CHK   = 4'd4;
  localparam logic [3:0] S_NEXT_CHK   = 4'd5;
  localparam logic [3:0] S_CHAIN_TEST = 4'd6;
  localparam logic [3:0] S_CHAIN_CHK  = 4'd7;
  localparam logic [3:0] S_DONE       = 4'd8;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free   = !out_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_valid_q;

  // Command decode and next state
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.wsel     = WSEL_ZERO;
    cmd_o.fin_st   = ST_OK;
    cmd_o.fin_res  = RES_ZERO;

    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        state_d = S_DONE;
        unique case (sts_i.kind) inside
          KIND_ALLOC: begin
            if (sts_i.n_zero) begin
              cmd_o.fin    = 1'b1;
              cmd_o.fin_st = ST_NOSPC;
            end else begin
              cmd_o.alloc_init = 1'b1;
              state_d          = S_SCAN_RD;
            end
          end
          KIND_NEXT: begin
            if (sts_i.cur_in_range) begin
              state_d = S_NEXT_CHK;
            end else begin
              cmd_o.fin    = 1'b1;
              cmd_o.fin_st = ST_CORRUPT;
            end
          end
          KIND_LINK, KIND_MARK_END, KIND_FREE_ONE: begin
            cmd_o.fin = 1'b1;
            if (sts_i.cur_in_range) begin
              cmd_o.wr     = 1'b1;
              cmd_o.fin_st = ST_OK;
              if (sts_i.kind == KIND_LINK) begin
                cmd_o.wsel = WSEL_LINK;
              end else if (sts_i.kind == KIND_MARK_END) begin
                cmd_o.wsel = WSEL_END;
              end else begin
                cmd_o.wsel        = WSEL_ZERO;
                cmd_o.release_ptr = 1'b1;
              end
            end else begin
              cmd_o.fin_st = ST_CORRUPT;
            end
          end
          KIND_FREE_CHAIN: begin
            state_d = S_CHAIN_TEST;
          end
          default: begin
            cmd_o.fin    = 1'b1;
            cmd_o.fin_st = ST_CORRUPT;
          end
        endcase
      end

      // Each scanned entry takes a read state, then a check state
      S_SCAN_RD: begin
        state_d = S_SCAN_CHK;
      end

      S_SCAN_CHK: begin
        if (sts_i.rd_zero) begin
          cmd_o.wr         = 1'b1;
          cmd_o.wsel       = WSEL_END;
          cmd_o.alloc_take = 1'b1;
          cmd_o.fin        = 1'b1;
          cmd_o.fin_st     = ST_OK;
          cmd_o.fin_res    = RES_CUR;
          state_d          = S_DONE;
        end else if (sts_i.scan_last) begin
          cmd_o.fin    = 1'b1;
          cmd_o.fin_st = ST_NOSPC;
          state_d      = S_DONE;
        end else begin
          cmd_o.scan_adv = 1'b1;
          state_d        = S_SCAN_RD;
        end
      end

      S_NEXT_CHK: begin
        cmd_o.fin = 1'b1;
        state_d   = S_DONE;
        if (sts_i.rd_end) begin
          cmd_o.fin_st = ST_OK;
        end else if (sts_i.rd_in_range) begin
          cmd_o.fin_st  = ST_OK;
          cmd_o.fin_res = RES_RD;
        end else begin
          cmd_o.fin_st = ST_CORRUPT;
        end
      end

      // Stop at chain end, reject a bad cluster
      S_CHAIN_TEST: begin
        if (sts_i.cur_zero) begin
          cmd_o.fin    = 1'b1;
          cmd_o.fin_st = ST_OK;
          state_d      = S_DONE;
        end else if (!sts_i.cur_in_range) begin
          cmd_o.fin    = 1'b1;
          cmd_o.fin_st = ST_CORRUPT;
          state_d      = S_DONE;
        end else begin
          state_d = S_CHAIN_CHK;
        end
      end

      // Release current entry and step to its successor; stop on a bad link or the step limit
      S_CHAIN_CHK: begin
        if (sts_i.rd_end || sts_i.rd_in_range) begin
          cmd_o.wr          = 1'b1;
          cmd_o.wsel        = WSEL_ZERO;
          cmd_o.release_ptr = 1'b1;
          cmd_o.chain_adv   = 1'b1;
          if (sts_i.steps_over) begin
            cmd_o.fin    = 1'b1;
            cmd_o.fin_st = ST_CORRUPT;
            state_d      = S_DONE;
          end else begin
            state_d = S_CHAIN_TEST;
          end
        end else begin
          cmd_o.fin    = 1'b1;
          cmd_o.fin_st = ST_CORRUPT;
          state_d      = S_DONE;
        end
      end

      S_DONE: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output beat holds until taken
  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // One request in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> !req_ready_o)
    else $error("request accepted while another is in flight");

  // A result never overwrites a beat that was not taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || rsp_ready_i))
    else $error("output beat overwritten");

  // Table writes only touch clusters in range
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr |-> sts_i.cur_in_range)
    else $error("table write outside cluster range");

  // A captured result reaches the output stage
  a_fin_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin |=> (state_q == S_DONE))
    else $error("result captured without output stage");

endmodule
`default_nettype wire

// ----- rtl/cluster_chain_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cluster chain allocator
// FAT-style link table with next-fit allocation and chain free.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request beat (kind, cluster, link_value); rsp returns
//   exactly one beat (status, cluster_out) per request, in order. The
//   cluster count register is written through cfg_we_i / cfg_wdata_i; the
//   user must do so only while no request is open, which the block itself
//   does not enforce. After reset the link table is swept to free, one
//   entry a cycle, over entries 0 to MAX_CLUSTERS; req.ready stays low until
//   the sweep is done. One request is worked at a time. Link, mark end, free
//   one and bad kinds finish in the dispatch state; next also checks the
//   entry read from the table. Allocate reads and checks each table entry
//   examined by the scan; free chain tests, reads and releases each cluster
//   in turn, stopping at a bad link or at the step limit. The table RAM's
//   single registered read port paces the scans and walks. The controller is
//   ready for the next request once the response is registered.
//   The response sits in an output register; a stalled receiver holds it,
//   and a finished request waits behind it until that beat is taken.
// ----------------------------------------------------------------------------
module cluster_chain_allocator
  import cca_pkg::*;
#(
  parameter int unsigned MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [LINK_W-1:0] cfg_wdata_i,
  cca_req_if.sink                req,
  cca_rsp_if.source              rsp
);

  cca_cmd_t cmd;
  cca_sts_t sts;

  cca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cca_datapath #(
    .MAX_CLUSTERS (MAX_CLUSTERS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .req_kind_i        (req.kind),
    .req_cluster_i     (req.cluster),
    .req_link_value_i  (req.link_value),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .rsp_status_o      (rsp.status),
    .rsp_cluster_out_o (rsp.cluster_out)
  );

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cluster chain allocator testbench
// Drives request beats through the valid/ready channels and checks every
// response beat against an in-bench copy of the link table, the next-fit
// pointer and the cluster count. A short directed run covers the edge cases.
// Random phases over several cluster counts follow, mostly chains that are
// allocated, linked, walked and freed, mixed with stray requests.
// ----------------------------------------------------------------------------
module tb;
  import cca_pkg::*;

  localparam logic [KIND_W-1:0] KIND_BAD_6    = 3'd6;
  localparam logic [KIND_W-1:0] KIND_BAD_7    = 3'd7;
  localparam logic [LINK_W-1:0] NO_CLUSTER    = '0;
  localparam int unsigned       SETTLE_CYCLES = 16;
  localparam int unsigned       HOLD_CYCLES   = 300;
  localparam int unsigned       CYCLE_LIMIT   = 20_000_000;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [LINK_W-1:0] cluster;
  } reply_t;

  // Shadow link table with next-fit pointer; holds expected response beats
  class cluster_link_scoreboard;
    logic [LINK_W-1:0] link_of [MAX_CLUSTERS_DEF+1];
    int unsigned       next_fit;
    int unsigned       active_count;
    reply_t            pending_replies[$];
    reply_t            last_reply;
    int unsigned       mismatches;
    int unsigned       replies_seen;

    function new();
      foreach (link_of[i]) link_of[i] = LINK_FREE;
      next_fit     = PTR_RESET;
      active_count = COUNT_RESET;
      mismatches   = 0;
      replies_seen = 0;
    endfunction

    function void set_count(logic [LINK_W-1:0] value);
      active_count = value;
    endfunction

    // Counts above the table size act as the table size
    function int unsigned usable();
      return (active_count > MAX_CLUSTERS_DEF) ? MAX_CLUSTERS_DEF : active_count;
    endfunction

    function bit in_span(int unsigned c);
      return c != 0 && c <= usable();
    endfunction

    // Follow one link; end marker reads as successor none
    function logic [ST_W-1:0] successor(int unsigned c, output int unsigned succ);
      succ = 0;
      if (!in_span(c)) return ST_CORRUPT;
      if (link_of[c] == END_MARK) return ST_OK;
      if (!in_span(32'(link_of[c]))) return ST_CORRUPT;
      succ = 32'(link_of[c]);
      return ST_OK;
    endfunction

    // Clear one entry and pull the next-fit pointer down to it
    function logic [ST_W-1:0] release_one(int unsigned c);
      if (!in_span(c)) return ST_CORRUPT;
      link_of[c] = LINK_FREE;
      if (c < next_fit) next_fit = c;
      return ST_OK;
    endfunction

    // Next-fit scan from the pointer, wrapping to cluster 1
    function logic [ST_W-1:0] claim_next_fit(output int unsigned got);
      int unsigned n;
      int unsigned c;
      int unsigned i;
      n   = usable();
      c   = next_fit;
      got = 0;
      if (c < 1 || c > n) c = 1;
      for (i = 0; i < n; i++) begin
        if (link_of[c] == LINK_FREE) begin
          link_of[c] = END_MARK;
          next_fit   = c + 1;
          got        = c;
          return ST_OK;
        end
        c++;
        if (c > n) c = 1;
      end
      return ST_NOSPC;
    endfunction

    // Walk and clear a chain; stop at the first bad link or after too many steps
    function logic [ST_W-1:0] release_chain(int unsigned first);
      int unsigned     c;
      int unsigned     succ;
      int unsigned     steps;
      logic [ST_W-1:0] st;
      c     = first;
      steps = 0;
      while (c != 0) begin
        st = successor(c, succ);
        if (st != ST_OK) return st;
        st = release_one(c);
        c  = succ;
        steps++;
        if (steps > usable()) return ST_CORRUPT;
      end
      return ST_OK;
    endfunction

    function reply_t predict_reply(logic [KIND_W-1:0] kind, logic [LINK_W-1:0] cluster,
                                   logic [LINK_W-1:0] link_value);
      reply_t      r;
      int unsigned got;
      got      = 0;
      r.status = ST_CORRUPT;
      case (kind)
        KIND_ALLOC:      r.status = claim_next_fit(got);
        KIND_NEXT:       r.status = successor(32'(cluster), got);
        KIND_LINK: begin
          if (in_span(32'(cluster))) begin
            link_of[cluster] = link_value;
            r.status = ST_OK;
          end
        end
        KIND_MARK_END: begin
          if (in_span(32'(cluster))) begin
            link_of[cluster] = END_MARK;
            r.status = ST_OK;
          end
        end
        KIND_FREE_CHAIN: r.status = release_chain(32'(cluster));
        KIND_FREE_ONE:   r.status = release_one(32'(cluster));
        default:         r.status = ST_CORRUPT;
      endcase
      r.cluster = (r.status == ST_OK) ? got[LINK_W-1:0] : NO_CLUSTER;
      return r;
    endfunction

    function void note_request(logic [KIND_W-1:0] kind, logic [LINK_W-1:0] cluster,
                               logic [LINK_W-1:0] link_value);
      last_reply = predict_reply(kind, cluster, link_value);
      pending_replies.push_back(last_reply);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_reply(logic [ST_W-1:0] status, logic [LINK_W-1:0] cluster_out);
      reply_t want;
      replies_seen++;
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("reply %0d arrived with none outstanding", replies_seen));
        return;
      end
      want = pending_replies.pop_front();
      if (status !== want.status)
        report_mismatch($sformatf("reply %0d status %0d, want %0d",
                                  replies_seen, status, want.status));
      if (cluster_out !== want.cluster)
        report_mismatch($sformatf("reply %0d cluster_out %0d, want %0d",
                                  replies_seen, cluster_out, want.cluster));
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [LINK_W-1:0] cfg_wdata_i;
  logic              idle_on       = 1'b1;
  logic              long_hold_req = 1'b0;
  logic              rsp_held;
  int unsigned       requests_sent = 0;

  cluster_link_scoreboard sb;

  cca_req_if req_ch ();
  cca_rsp_if rsp_ch ();

  cluster_chain_allocator #(
    .MAX_CLUSTERS(MAX_CLUSTERS_DEF)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // One long receiver hold-off once requested, so the block backs up
  initial begin : long_hold
    rsp_held = 1'b0;
    wait (long_hold_req);
    @(posedge clk_i);
    rsp_held <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rsp_held <= 1'b0;
  end

  // Check response beats, then drive ready with short random stall bursts
  initial begin : rsp_side
    int unsigned stall_left;
    stall_left   = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_ch.valid && rsp_ch.ready) sb.check_reply(rsp_ch.status, rsp_ch.cluster_out);
      if (rsp_held) begin
        rsp_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one request beat, with an optional idle burst first; hold until taken
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [LINK_W-1:0] cluster,
                              input logic [LINK_W-1:0] link_value);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.kind       <= kind;
    req_ch.cluster    <= cluster;
    req_ch.link_value <= link_value;
    do @(posedge clk_i); while (!req_ch.ready);
    sb.note_request(kind, cluster, link_value);
    requests_sent++;
  endtask

  // Drop valid and wait until every expected beat is back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [LINK_W-1:0] value);
    wait_drained();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    sb.set_count(value);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly in-range clusters, some none, some anything
  function automatic logic [LINK_W-1:0] pick_cluster();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7 && sb.usable() != 0) return LINK_W'($urandom_range(1, sb.usable()));
    if (r == 7) return NO_CLUSTER;
    return LINK_W'($urandom);
  endfunction

  function automatic logic [LINK_W-1:0] pick_link();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 3) return END_MARK;
    if (r < 5) return LINK_FREE;
    if (r < 15) return pick_cluster();
    return LINK_W'($urandom);
  endfunction

  // Allocate a short chain, link it, maybe break it, maybe walk it, then usually release it
  task automatic build_chain();
    logic [LINK_W-1:0] members[$];
    logic [LINK_W-1:0] walk;
    int unsigned       len;
    int unsigned       i;
    int unsigned       pick;
    int unsigned       last;
    len = $urandom_range(1, 6);
    for (i = 0; i < len; i++) begin
      send_request(KIND_ALLOC, LINK_W'($urandom), LINK_W'($urandom));
      if (sb.last_reply.status == ST_OK) members.push_back(sb.last_reply.cluster);
    end
    if (members.size() == 0) return;
    last = members.size() - 1;
    for (i = 0; i < last; i++) send_request(KIND_LINK, members[i], members[i+1]);
    pick = $urandom_range(0, 19);
    if (pick == 0) send_request(KIND_LINK, members[last], members[0]);
    else if (pick == 1) send_request(KIND_LINK, members[last], pick_link());
    else if (pick == 2) send_request(KIND_MARK_END, members[last], LINK_W'($urandom));
    if ($urandom_range(0, 1) == 1) begin
      walk = members[0];
      for (i = 0; i <= last + 1; i++) begin
        send_request(KIND_NEXT, walk, LINK_W'($urandom));
        if (sb.last_reply.status != ST_OK || sb.last_reply.cluster == NO_CLUSTER) break;
        walk = sb.last_reply.cluster;
      end
    end
    pick = $urandom_range(0, 19);
    if (pick < 12)
      send_request(KIND_FREE_CHAIN, members[0], LINK_W'($urandom));
    else if (pick < 14)
      send_request(KIND_FREE_CHAIN, members[$urandom_range(0, last)], LINK_W'($urandom));
    else if (pick < 16)
      send_request(KIND_FREE_ONE, members[$urandom_range(0, last)], LINK_W'($urandom));
  endtask

  task automatic run_phase(input logic [LINK_W-1:0] count, input int unsigned items);
    int unsigned first;
    int unsigned c;
    write_count(count);
    first = requests_sent;
    // Open up room in small tables left full by earlier phases
    if (sb.usable() <= 64) begin
      for (c = 1; c <= sb.usable(); c++)
        if ($urandom_range(0, 1) == 1)
          send_request(KIND_FREE_ONE, LINK_W'(c), LINK_W'($urandom));
    end
    while (requests_sent - first < items) begin
      if ($urandom_range(0, 9) < 6) build_chain();
      else send_request(KIND_W'($urandom_range(KIND_ALLOC, KIND_BAD_7)), pick_cluster(),
                        pick_link());
    end
  endtask

  initial begin : stimulus
    req_ch.valid      = 1'b0;
    req_ch.kind       = KIND_ALLOC;
    req_ch.cluster    = NO_CLUSTER;
    req_ch.link_value = LINK_FREE;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    sb                = new();
    rst_ni            = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed edge cases at the reset cluster count
    send_request(KIND_NEXT, NO_CLUSTER, LINK_FREE);       // cluster none
    send_request(KIND_NEXT, 11'd1, LINK_FREE);            // stored link is free
    send_request(KIND_ALLOC, NO_CLUSTER, LINK_FREE);
    send_request(KIND_ALLOC, NO_CLUSTER, LINK_FREE);
    send_request(KIND_LINK, 11'd1, 11'd2);
    send_request(KIND_NEXT, 11'd1, LINK_FREE);
    send_request(KIND_NEXT, 11'd2, LINK_FREE);            // chain end
    send_request(KIND_LINK, 11'd2, 11'd1500);             // out-of-range link stored
    send_request(KIND_NEXT, 11'd2, LINK_FREE);
    send_request(KIND_LINK, 11'd2, END_MARK);             // link value as end marker
    send_request(KIND_MARK_END, 11'd1024, LINK_FREE);     // top cluster
    send_request(KIND_NEXT, 11'd1024, LINK_FREE);
    send_request(KIND_LINK, 11'd1025, 11'd3);             // just past the count
    send_request(KIND_MARK_END, 11'd2047, 11'd2047);
    send_request(KIND_FREE_ONE, NO_CLUSTER, LINK_FREE);
    send_request(KIND_FREE_CHAIN, NO_CLUSTER, LINK_FREE); // empty chain
    send_request(KIND_FREE_CHAIN, 11'd1, LINK_FREE);      // pulls the pointer down
    send_request(KIND_ALLOC, NO_CLUSTER, LINK_FREE);
    send_request(KIND_BAD_6, 11'd5, 11'd7);
    send_request(KIND_BAD_7, 11'd2047, 11'd2047);
    send_request(KIND_LINK, 11'd3, 11'd4);                // chain with a bad link
    send_request(KIND_LINK, 11'd4, 11'd1800);
    send_request(KIND_FREE_CHAIN, 11'd3, LINK_FREE);
    send_request(KIND_LINK, 11'd6, 11'd7);                // chain that loops
    send_request(KIND_LINK, 11'd7, 11'd6);
    send_request(KIND_FREE_CHAIN, 11'd6, LINK_FREE);
    send_request(KIND_LINK, 11'd1, LINK_FREE);            // free through link

    // Random phases over a spread of cluster counts
    run_phase(11'd0, 30);
    run_phase(11'd1, 40);
    run_phase(11'd2047, 120);
    run_phase(11'd8, 200);
    run_phase(11'd3, 120);
    run_phase(11'd1365, 100);
    long_hold_req = 1'b1;
    run_phase(11'd32, 250);
    run_phase(11'd682, 100);
    run_phase(11'd1024, 60);
    run_phase(11'd64, 250);
    run_phase(11'd5, 150);
    idle_on = 1'b0;
    run_phase(11'd16, 300);

    wait_drained();
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
